@@ rtl/sha1_hash_engine_core_assert.svh @@
// Assertion macros used by the port-level checker of the SHA-1 hash engine.
`ifndef SHA1_HASH_ENGINE_CORE_ASSERT_SVH
`define SHA1_HASH_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge of clock, off in reset.
`define SHA1_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sha1 check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising edge of clock, off in reset.
`define SHA1_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sha1 check failed: next-cycle implication");

`endif

@@ rtl/sha1_pkg.sv @@
// Shared types, constants and helper functions of the SHA-1 hash engine.
`default_nettype none

package sha1_pkg;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;

   localparam logic [31:0] K_CH    = 32'h5A827999;
   localparam logic [31:0] K_PAR_A = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJ   = 32'h8F1BBCDC;
   localparam logic [31:0] K_PAR_B = 32'hCA62C1D6;

   localparam logic [31:0] PAD_WORD   = 32'h80000000;
   localparam logic [2:0]  FULL_BYTES = 3'd4;
   localparam logic [3:0]  POS_LEN_HI = 4'd14;
   localparam logic [3:0]  POS_LEN_LO = 4'd15;
   localparam logic [6:0]  LAST_ROUND = 7'd79;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  valid_bytes;
      logic        last;
   } sha1_req_type;

   typedef struct packed {
      logic [31:0] digest_word0;
      logic [31:0] digest_word1;
      logic [31:0] digest_word2;
      logic [31:0] digest_word3;
      logic [31:0] digest_word4;
   } sha1_rsp_type;

   typedef enum logic [2:0] {
      ST_ACCEPT,
      ST_PAD,
      ST_ROUND,
      ST_UPDATE,
      ST_OUTPUT
   } sha1_state_type;

   // Source of the word shifted into the schedule window on a push.
   typedef enum logic [2:0] {
      SEL_DATA,
      SEL_PAD,
      SEL_ZERO,
      SEL_LEN_HI,
      SEL_LEN_LO
   } sha1_wsel_type;

   // Round group: selects the round function and constant.
   typedef enum logic [1:0] {
      PH_CH,
      PH_PAR_A,
      PH_MAJ,
      PH_PAR_B
   } sha1_phase_type;

   typedef struct packed {
      logic           push;
      sha1_wsel_type  word_sel;
      logic           count_add;
      logic           load_work;
      logic           round;
      sha1_phase_type phase;
      logic           chain_add;
      logic           out_load;
   } sha1_cmd_type;

   // Number of message bytes a word really carries.
   function automatic logic [2:0] sha1_eff_bytes(input logic [2:0] vb, input logic last);
      logic [2:0] res;
      begin
         res = vb;
         if (!last || vb > FULL_BYTES) begin
            res = FULL_BYTES;
         end
         return res;
      end
   endfunction

   // Below four valid bytes, clears the rest and places the padding byte.
   function automatic logic [31:0] sha1_fmt_word(input logic [31:0] data,
                                                 input logic [2:0] vb);
      logic [31:0] res;
      begin
         case (vb)
            3'd0: res = PAD_WORD;
            3'd1: res = {data[31:24], 24'h800000};
            3'd2: res = {data[31:16], 16'h8000};
            3'd3: res = {data[31:8], 8'h80};
            default: res = data;
         endcase
         return res;
      end
   endfunction

   function automatic logic [31:0] sha1_k(input sha1_phase_type ph);
      logic [31:0] res;
      begin
         case (ph)
            PH_CH:    res = K_CH;
            PH_PAR_A: res = K_PAR_A;
            PH_MAJ:   res = K_MAJ;
            PH_PAR_B: res = K_PAR_B;
            default:  res = K_CH;
         endcase
         return res;
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/sha1_ctrl.sv @@
// Sequencer of the SHA-1 hash engine: word position, padding and round count.
`default_nettype none

module sha1_ctrl
   import sha1_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire sha1_req_type req_payload,
   output logic              req_stall,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output sha1_cmd_type      cmd
);

   sha1_state_type state_ff, state_in;
   logic [3:0] pos_ff, pos_in;
   logic [6:0] rnd_ff, rnd_in;
   logic       pad_ff, pad_in;       // message ended, padding in progress
   logic       pad80_ff, pad80_in;   // padding byte still needs its own word
   logic       hi_done_ff, hi_done_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         pos_ff       <= '0;
         rnd_ff       <= '0;
         pad_ff       <= 1'b0;
         pad80_ff     <= 1'b0;
         hi_done_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rnd_ff       <= rnd_in;
         pad_ff       <= pad_in;
         pad80_ff     <= pad80_in;
         hi_done_ff   <= hi_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign req_stall = (state_ff != ST_ACCEPT);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      rnd_in       = rnd_ff;
      pad_in       = pad_ff;
      pad80_in     = pad80_ff;
      hi_done_in   = hi_done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.word_sel = SEL_DATA;
      cmd.phase    = PH_CH;

      case (state_ff)
         ST_ACCEPT: begin
            if (req_valid) begin
               cmd.push      = 1'b1;
               cmd.count_add = 1'b1;
               pos_in        = pos_ff + 4'd1;
               if (req_payload.last) begin
                  pad_in   = 1'b1;
                  pad80_in = (sha1_eff_bytes(req_payload.valid_bytes, 1'b1) == FULL_BYTES);
               end
               if (pos_ff == POS_LEN_LO) begin
                  cmd.load_work = 1'b1;
                  rnd_in        = '0;
                  state_in      = ST_ROUND;
               end else if (req_payload.last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.push = 1'b1;
            pos_in   = pos_ff + 4'd1;
            if (pad80_ff) begin
               cmd.word_sel = SEL_PAD;
               pad80_in     = 1'b0;
            end else if (pos_ff == POS_LEN_HI) begin
               cmd.word_sel = SEL_LEN_HI;
               hi_done_in   = 1'b1;
            end else if (pos_ff == POS_LEN_LO && hi_done_ff) begin
               cmd.word_sel = SEL_LEN_LO;
            end else begin
               cmd.word_sel = SEL_ZERO;
            end
            if (pos_ff == POS_LEN_LO) begin
               cmd.load_work = 1'b1;
               rnd_in        = '0;
               state_in      = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (rnd_ff < 7'd20) begin
               cmd.phase = PH_CH;
            end else if (rnd_ff < 7'd40) begin
               cmd.phase = PH_PAR_A;
            end else if (rnd_ff < 7'd60) begin
               cmd.phase = PH_MAJ;
            end else begin
               cmd.phase = PH_PAR_B;
            end
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.chain_add = 1'b1;
            if (hi_done_ff) begin
               state_in = ST_OUTPUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_ACCEPT;
            end
         end
         ST_OUTPUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               pad_in       = 1'b0;
               pad80_in     = 1'b0;
               hi_done_in   = 1'b0;
               state_in     = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/sha1_dp.sv @@
// Datapath of the SHA-1 hash engine: schedule window, round logic, chain value.
`default_nettype none

module sha1_dp
   import sha1_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire sha1_req_type req_payload,
   input  wire sha1_cmd_type cmd,
   output sha1_rsp_type      rsp_payload
);

   logic [31:0] win_ff [16];
   logic [31:0] chain_ff [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [63:0] count_ff, count_in;
   sha1_rsp_type out_ff;

   logic [2:0]  eff_bytes;
   logic [31:0] push_word, sched_new, win_in_word;
   logic [31:0] f_val, t_val;

   assign eff_bytes = sha1_eff_bytes(req_payload.valid_bytes, req_payload.last);

   always_comb begin
      case (cmd.word_sel)
         SEL_DATA:   push_word = sha1_fmt_word(req_payload.data_word, eff_bytes);
         SEL_PAD:    push_word = PAD_WORD;
         SEL_ZERO:   push_word = '0;
         SEL_LEN_HI: push_word = count_ff[63:32];
         SEL_LEN_LO: push_word = count_ff[31:0];
         default:    push_word = '0;
      endcase
   end

   // Window entry i holds schedule word t+i; the next word is W[t+16].
   always_comb begin
      sched_new = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
      sched_new = {sched_new[30:0], sched_new[31]};
   end

   assign win_in_word = cmd.push ? push_word : sched_new;

   always_comb begin
      case (cmd.phase)
         PH_CH:    f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         PH_MAJ:   f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         PH_PAR_A: f_val = b_ff ^ c_ff ^ d_ff;
         PH_PAR_B: f_val = b_ff ^ c_ff ^ d_ff;
         default:  f_val = b_ff ^ c_ff ^ d_ff;
      endcase
      t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + win_ff[0] + sha1_k(cmd.phase);
   end

   always_ff @(posedge clock) begin
      if (cmd.push || cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[15] <= win_in_word;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_work) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end else if (cmd.round) begin
         a_ff <= t_val;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.out_load) begin
         count_in = '0;
      end else if (cmd.count_add) begin
         count_in = count_ff + {58'd0, eff_bytes, 3'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         chain_ff[0] <= IV0;
         chain_ff[1] <= IV1;
         chain_ff[2] <= IV2;
         chain_ff[3] <= IV3;
         chain_ff[4] <= IV4;
      end else begin
         count_ff <= count_in;
         if (cmd.out_load) begin
            chain_ff[0] <= IV0;
            chain_ff[1] <= IV1;
            chain_ff[2] <= IV2;
            chain_ff[3] <= IV3;
            chain_ff[4] <= IV4;
         end else if (cmd.chain_add) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
            chain_ff[4] <= chain_ff[4] + e_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.digest_word0 <= chain_ff[0];
         out_ff.digest_word1 <= chain_ff[1];
         out_ff.digest_word2 <= chain_ff[2];
         out_ff.digest_word3 <= chain_ff[3];
         out_ff.digest_word4 <= chain_ff[4];
      end
   end

   assign rsp_payload = out_ff;

endmodule

`default_nettype wire

@@ rtl/sha1_hash_engine_core.sv @@
// Top level of the SHA-1 hash engine: sequencer plus datapath.
// Words are accepted back to back while the sequencer waits for message
// words; every 16th word starts a compression (80 rounds of the single round
// unit, then the chain update). After the last word, padding words are pushed
// in, one or two blocks are compressed, and the output load registers the digest.
// Synchronous active-high reset loads the initial chain value and empties the block.
`default_nettype none

module sha1_hash_engine_core
   import sha1_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire sha1_req_type req_payload,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output sha1_rsp_type      rsp_payload
);

   // The sequencer steers everything through one command struct. It owns
   // the block position, the padding flags, the round counter and the
   // valid bit of the result register.
   sha1_cmd_type cmd;

   // Input beats are taken only while the sequencer waits for message words.
   // A finished digest sits in the output register, so the next message can
   // start streaming in while the previous digest beat is still stalled.
   sha1_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd)
   );

   // The datapath holds the 16-word schedule window, which doubles as the
   // block buffer while words arrive, the working variables, the chain value
   // and the 64-bit bit counter that supplies the length words.
   sha1_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

@@ rtl/sha1_chk.sv @@
// Port-level checker of the SHA-1 hash engine and its bind to the top level.
`default_nettype none

`include "sha1_hash_engine_core_assert.svh"

module sha1_chk
   import sha1_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire sha1_req_type req_payload,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire sha1_rsp_type rsp_payload
);

   // A stalled digest beat stays offered and unchanged.
   `SHA1_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `SHA1_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_payload))

   // The final word always starts padding work, so the input must stall next.
   `SHA1_ASSERT_NEXT(a_last_stalls, req_valid && !req_stall && req_payload.last, req_stall)

   // A new digest is produced only out of a busy period of the engine.
   `SHA1_ASSERT_NOW(a_rsp_after_busy, $rose(rsp_valid), $past(req_stall))

endmodule

bind sha1_hash_engine_core sha1_chk u_sha1_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench of the SHA-1 hash engine: directed and random messages vs. a digest model.
`timescale 1ns / 1ps

module testbench;
   import sha1_pkg::*;

   // Scoreboard for the digest stream. It keeps its own copy of the hash
   // state. Every accepted input beat is folded into that state, and each
   // finished message leaves one expected digest in a queue. Digests that
   // come out of the block are compared against the oldest entry.
   class sha1_digest_board;
      logic [31:0]  chain [5];
      logic [31:0]  msg_block [16];
      logic [3:0]   fill;
      logic [63:0]  bit_count;
      sha1_rsp_type expected_digests [$];
      int unsigned  failures;
      int unsigned  digests_checked;
      int unsigned  words_noted;
      int unsigned  messages_noted;
      int unsigned  partial_lasts;

      function new();
         failures = 0;
         digests_checked = 0;
         words_noted = 0;
         messages_noted = 0;
         partial_lasts = 0;
         restart();
      endfunction

      function void restart();
         chain = '{IV0, IV1, IV2, IV3, IV4};
         fill = 4'd0;
         bit_count = 64'd0;
      endfunction

      function logic [31:0] rotl(logic [31:0] x, int unsigned n);
         return (x << n) | (x >> (32 - n));
      endfunction

      function void compress();
         logic [31:0] sched [80];
         logic [31:0] a, b, c, d, e, f, k, tmp;
         int i;
         for (i = 0; i < 16; i++) begin
            sched[i] = msg_block[i];
         end
         for (i = 16; i < 80; i++) begin
            sched[i] = rotl(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
         end
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (i = 0; i < 80; i++) begin
            if (i < 20) begin
               f = (b & c) | (~b & d);
               k = K_CH;
            end else if (i < 40) begin
               f = b ^ c ^ d;
               k = K_PAR_A;
            end else if (i < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = K_MAJ;
            end else begin
               f = b ^ c ^ d;
               k = K_PAR_B;
            end
            tmp = rotl(a, 5) + f + e + sched[i] + k;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = tmp;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      function void push(logic [31:0] w);
         msg_block[fill] = w;
         fill = fill + 4'd1;
         if (fill == 4'd0) begin
            compress();
         end
      endfunction

      function void note_word(sha1_req_type beat);
         logic [2:0]  nbytes;
         logic [31:0] word;
         int          shift;
         nbytes = beat.valid_bytes;
         if (!beat.last || nbytes > FULL_BYTES) begin
            nbytes = FULL_BYTES;
         end
         word = beat.data_word;
         if (nbytes < FULL_BYTES) begin
            shift = 8 * int'(nbytes);
            word = (word & ~(32'hFFFF_FFFF >> shift)) | (32'h80 << (24 - shift));
         end
         bit_count += 64'(8 * int'(nbytes));
         push(word);
         words_noted++;
         if (!beat.last) begin
            return;
         end
         if (nbytes == FULL_BYTES) begin
            push(PAD_WORD);
         end else begin
            partial_lasts++;
         end
         while (fill != POS_LEN_HI) begin
            push(32'd0);
         end
         push(bit_count[63:32]);
         push(bit_count[31:0]);
         expected_digests.push_back('{digest_word0: chain[0], digest_word1: chain[1],
                                      digest_word2: chain[2], digest_word3: chain[3],
                                      digest_word4: chain[4]});
         messages_noted++;
         restart();
      endfunction

      function void flag(string what);
         if (failures < 10) begin
            $display("ERROR: %s", what);
         end
         failures++;
      endfunction

      function void check_digest(sha1_rsp_type got);
         sha1_rsp_type     want;
         logic [4:0][31:0] got_w, want_w;
         int               i;
         if (expected_digests.size() == 0) begin
            flag($sformatf("digest %h arrived with none outstanding", got));
            return;
         end
         want = expected_digests.pop_front();
         got_w = got;
         want_w = want;
         for (i = 0; i < 5; i++) begin
            if (got_w[4-i] !== want_w[4-i]) begin
               flag($sformatf("digest %0d word%0d: expected %h, got %h",
                              digests_checked, i, want_w[4-i], got_w[4-i]));
            end
         end
         digests_checked++;
      endfunction
   endclass

   // The longest receiver hold-off, in cycles. It is long enough that the
   // block finishes a digest, cannot hand it over and pushes back on input.
   localparam int unsigned LONG_HOLD_CYCLES = 3000;
   localparam int unsigned RANDOM_ITEMS     = 1630;
   localparam int unsigned MAX_SEND_GAP     = 40;
   localparam int unsigned MAX_SHORT_STALL  = 60;
   // After the last word the block may still take padding beats and compress
   // two blocks, each of 80 rounds followed by the chain update.
   localparam int unsigned DRAIN_CYCLES     = 250;
   // Worst case per beat: the longest send gap, a final word that needs two
   // compressions, and the longest ordinary receiver stall. That sum over all
   // beats, plus the one long hold-off, is taken four times over.
   localparam int unsigned TIMEOUT_CYCLES   =
      4 * ((RANDOM_ITEMS + 100) * (MAX_SEND_GAP + 200 + MAX_SHORT_STALL) + LONG_HOLD_CYCLES);

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   sha1_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_stall;
   sha1_rsp_type rsp_payload;

   sha1_digest_board board = new();

   // When set, the sender offers beats back to back with no idle cycles.
   bit burst_mode = 1'b0;

   sha1_hash_engine_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offers one input beat and waits until the block takes it. An idle gap
   // of random length may come first. The valid line is lowered only when
   // a gap is taken, so back-to-back beats never see a low-then-high pulse
   // within one time step.
   task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                            input logic last);
      int unsigned  idle;
      int unsigned  r;
      sha1_req_type beat;
      beat = '{data_word: data, valid_bytes: nbytes, last: last};
      r = $urandom_range(0, 99);
      if (burst_mode || r < 60) begin
         idle = 0;
      end else if (r < 90) begin
         idle = $urandom_range(1, 3);
      end else begin
         idle = $urandom_range(8, MAX_SEND_GAP);
      end
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= beat;
      // Stall is sampled as it stood just before the edge, so the beat is
      // taken exactly at the edge where it was low.
      do @(posedge clock); while (req_stall);
      board.note_word(beat);
   endtask

   // Main stimulus: reset, a directed set of messages, then random messages.
   initial begin : stimulus
      int unsigned sent;
      int unsigned len;
      int unsigned i;
      logic [31:0] data;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // One-word messages: every count of valid bytes in the final word,
      // including the empty message, counts above four, and "abc".
      send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
      send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
      send_word(32'h0000_0000, 3'd2, 1'b1);
      send_word(32'h6162_6300, 3'd3, 1'b1);
      send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
      send_word(32'h1234_5678, 3'd5, 1'b1);
      send_word(32'h89AB_CDEF, 3'd6, 1'b1);
      send_word(32'h0000_0000, 3'd7, 1'b1);

      // Fourteen full words: the padding word lands in slot 14, so the
      // length must spill into a second block. Non-final beats carry every
      // valid-byte count, which the block must ignore.
      for (i = 0; i < 14; i++) begin
         send_word(i[0] ? 32'hFFFF_FFFF : 32'h0, (i == 13) ? FULL_BYTES : i[2:0],
                   i == 13);
      end

      // Random messages, mostly short, now and then spanning several blocks.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 70) : $urandom_range(1, 20);
         burst_mode = ($urandom_range(0, 3) == 0);
         for (i = 1; i <= len; i++) begin
            case ($urandom_range(0, 15))
               0:       data = 32'h0;
               1:       data = 32'hFFFF_FFFF;
               default: data = $urandom;
            endcase
            send_word(data, 3'($urandom_range(0, 7)), i == len);
         end
         sent += len;
      end
      req_valid <= 1'b0;

      while (board.expected_digests.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d words in %0d messages, %0d ending in a partial word.",
               board.words_noted, board.messages_noted, board.partial_lasts);
      $display("Compared %0d digests with %0d errors, across a %0d-cycle output hold-off.",
               board.digests_checked, board.failures, LONG_HOLD_CYCLES);
      if (board.failures == 0 && board.expected_digests.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Output monitor: a digest beat is taken at an edge where valid was high
   // and our stall was low, both read as they stood before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_digest(rsp_payload);
      end
   end

   // Receiver back-pressure. Each pass drives the stall line once and holds
   // it for a random span: quiet stretches, short and long stalls, and one
   // very long hold-off once a dozen digests have gone by. During that hold
   // the sender keeps offering beats, so the block fills up and stalls.
   initial begin : rsp_hold_off
      int unsigned span;
      int unsigned r;
      bit          long_hold_done;
      long_hold_done = 1'b0;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (!long_hold_done && board.digests_checked >= 12) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            span = LONG_HOLD_CYCLES;
         end else if (r < 5) begin
            rsp_stall <= 1'b0;
            span = $urandom_range(100, 300);
         end else if (r < 55) begin
            rsp_stall <= 1'b0;
            span = $urandom_range(1, 8);
         end else if (r < 90) begin
            rsp_stall <= 1'b1;
            span = $urandom_range(1, 4);
         end else begin
            rsp_stall <= 1'b1;
            span = $urandom_range(10, MAX_SHORT_STALL);
         end
         repeat (span) @(posedge clock);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("FAILURE");
      $finish;
   end

endmodule
